FILE: src/button_gesture_detector_top_assert.svh
// assertion macros for the button gesture detector
`ifndef BUTTON_GESTURE_DETECTOR_TOP_ASSERT_SVH
`define BUTTON_GESTURE_DETECTOR_TOP_ASSERT_SVH

// same-cycle implication, checked outside reset
`define BGD_ASSERT_NOW(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication, checked outside reset
`define BGD_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

FILE: src/bgd_pkg.sv
// shared widths, codes and register reset values for the button gesture detector
package bgd_pkg;

  localparam int unsigned TIME_W    = 32;
  localparam int unsigned CFG_W     = 16;
  localparam int unsigned CFG_IDX_W = 8;
  localparam int unsigned EV_W      = 3;
  localparam int unsigned IN_DATA_W = 40;
  localparam int unsigned OUT_DATA_W = 8;

  // request kinds carried on in_tuser
  localparam logic OP_POLL    = 1'b0;
  localparam logic OP_CONSUME = 1'b1;

  // configuration register indexes
  localparam logic [CFG_IDX_W-1:0] REG_HOLD_THR     = 8'd0;
  localparam logic [CFG_IDX_W-1:0] REG_SHORT_MIN    = 8'd1;
  localparam logic [CFG_IDX_W-1:0] REG_SHORT_MAX    = 8'd2;
  localparam logic [CFG_IDX_W-1:0] REG_DOUBLE_WIN   = 8'd3;

  localparam logic [CFG_W-1:0] HOLD_THR_RST   = 16'd1000;
  localparam logic [CFG_W-1:0] SHORT_MIN_RST  = 16'd30;
  localparam logic [CFG_W-1:0] SHORT_MAX_RST  = 16'd500;
  localparam logic [CFG_W-1:0] DOUBLE_WIN_RST = 16'd0;

  // latched event bit positions
  localparam int unsigned EV_CLICK  = 0;
  localparam int unsigned EV_DOUBLE = 1;
  localparam int unsigned EV_LONG   = 2;

endpackage

FILE: src/button_gesture_detector_top.sv
// top level of the button gesture detector: request register, gesture logic, result register
// Takes one request per cycle unless a result waits on out_tready, and returns one result
// per request. The request register loads at the accepting edge and the result register
// loads from it when no result waits, raising out_tvalid. A poll request (in_tuser 0)
// samples the active-low pin with a millisecond timestamp and returns the latched
// click, double-click and long-press flags after the update; a consume request
// (in_tuser 1) returns the flags and clears them. The gesture state is updated in the
// same cycle the result register loads, so back-to-back requests see each other's
// effect without a gap. The result register stalls the request register only while a
// result waits on out_tready. Configuration writes are always accepted; indexes past
// the double-click window register are ignored.
module button_gesture_detector_top (
  input  logic                               clk,
  input  logic                               rst_n,
  input  logic                               in_tvalid,
  output logic                               in_tready,
  // [0] pin_level, [32:1] now_time, upper bits zero
  input  logic [bgd_pkg::IN_DATA_W-1:0]      in_tdata,
  // [0] operation
  input  logic                               in_tuser,
  output logic                               out_tvalid,
  input  logic                               out_tready,
  // [0] click, [1] dbl_click, [2] hold_press, upper bits zero
  output logic [bgd_pkg::OUT_DATA_W-1:0]     out_tdata,
  input  logic                               cfg_valid,
  output logic                               cfg_ready,
  input  logic [bgd_pkg::CFG_IDX_W-1:0]      cfg_index,
  input  logic [bgd_pkg::CFG_W-1:0]          cfg_data
);
  import bgd_pkg::*;

  logic [CFG_W-1:0]  hold_thr_r, short_min_r, short_max_r, double_win_r;

  logic              s1_valid_r;
  logic              s1_op_r;
  logic              s1_pin_r;
  logic [TIME_W-1:0] s1_time_r;

  logic              out_valid_r;
  logic [EV_W-1:0]   out_ev_r;

  logic              was_pressed_r, was_pressed_nxt;
  logic [TIME_W-1:0] press_start_r, press_start_nxt;
  logic              long_done_r, long_done_nxt;
  logic              await_r, await_nxt;
  logic [TIME_W-1:0] first_rel_r, first_rel_nxt;
  logic [EV_W-1:0]   ev_r, ev_nxt;
  logic [EV_W-1:0]   res_ev;

  logic              advance, s1_fire;
  logic              poll_fire, cons_fire;
  logic              pressed;
  logic [TIME_W:0]   d_ps, d_fr;
  logic              neg_ps, neg_fr;
  logic              win_nz, hold_long, click_ok, in_win, rel_set;

  assign cfg_ready  = 1'b1;
  assign advance    = !out_valid_r || out_tready;
  assign s1_fire    = s1_valid_r && advance;
  assign poll_fire  = s1_fire && (s1_op_r == OP_POLL);
  assign cons_fire  = s1_fire && (s1_op_r == OP_CONSUME);
  assign in_tready  = !s1_valid_r || advance;
  assign out_tvalid = out_valid_r;
  assign out_tdata  = {{(OUT_DATA_W-EV_W){1'b0}}, out_ev_r};

  // configuration registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      hold_thr_r   <= HOLD_THR_RST;
      short_min_r  <= SHORT_MIN_RST;
      short_max_r  <= SHORT_MAX_RST;
      double_win_r <= DOUBLE_WIN_RST;
    end else if (cfg_valid && cfg_ready) begin
      unique case (cfg_index)
        REG_HOLD_THR:   hold_thr_r   <= cfg_data;
        REG_SHORT_MIN:  short_min_r  <= cfg_data;
        REG_SHORT_MAX:  short_max_r  <= cfg_data;
        REG_DOUBLE_WIN: double_win_r <= cfg_data;
        default: ;
      endcase
    end
  end

  // request register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r <= 1'b0;
    end else if (in_tready) begin
      s1_valid_r <= in_tvalid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_tvalid && in_tready) begin
      s1_op_r   <= in_tuser;
      s1_pin_r  <= in_tdata[0];
      s1_time_r <= in_tdata[TIME_W:1];
    end
  end

  // time differences as signed 33-bit values
  assign pressed   = !s1_pin_r;
  assign d_ps      = {1'b0, s1_time_r} - {1'b0, press_start_r};
  assign d_fr      = {1'b0, s1_time_r} - {1'b0, first_rel_r};
  assign neg_ps    = d_ps[TIME_W];
  assign neg_fr    = d_fr[TIME_W];
  assign win_nz    = |double_win_r;
  assign hold_long = !neg_ps && (d_ps[TIME_W-1:0] >= {{(TIME_W-CFG_W){1'b0}}, hold_thr_r});
  assign click_ok  = !long_done_r && !neg_ps &&
                     (d_ps[TIME_W-1:0] >= {{(TIME_W-CFG_W){1'b0}}, short_min_r}) &&
                     (d_ps[TIME_W-1:0] <= {{(TIME_W-CFG_W){1'b0}}, short_max_r});
  assign in_win    = neg_fr || (d_fr[TIME_W-1:0] <= {{(TIME_W-CFG_W){1'b0}}, double_win_r});

  // gesture update
  always_comb begin
    was_pressed_nxt = was_pressed_r;
    press_start_nxt = press_start_r;
    long_done_nxt   = long_done_r;
    await_nxt       = await_r;
    first_rel_nxt   = first_rel_r;
    ev_nxt          = ev_r;
    res_ev          = ev_r;
    rel_set         = 1'b0;
    if (s1_op_r == OP_CONSUME) begin
      ev_nxt = '0;
    end else begin
      if (pressed && !was_pressed_r) begin
        press_start_nxt = s1_time_r;
        long_done_nxt   = 1'b0;
      end else if (!pressed && was_pressed_r) begin
        if (click_ok) begin
          if (await_r && win_nz && in_win) begin
            ev_nxt[EV_DOUBLE] = 1'b1;
            await_nxt         = 1'b0;
            first_rel_nxt     = '0;
          end else begin
            ev_nxt[EV_CLICK] = 1'b1;
            if (win_nz) begin
              await_nxt     = 1'b1;
              first_rel_nxt = s1_time_r;
              rel_set       = 1'b1;
            end else begin
              await_nxt     = 1'b0;
              first_rel_nxt = '0;
            end
          end
        end
        press_start_nxt = '0;
        long_done_nxt   = 1'b0;
      end else if (pressed && !long_done_r && hold_long) begin
        ev_nxt[EV_LONG] = 1'b1;
        long_done_nxt   = 1'b1;
        await_nxt       = 1'b0;
        first_rel_nxt   = '0;
      end
      was_pressed_nxt = pressed;
      // window expiry; a fresh first release is always inside a nonzero window
      if (await_nxt && (!win_nz || (!rel_set && !in_win))) begin
        await_nxt     = 1'b0;
        first_rel_nxt = '0;
      end
      res_ev = ev_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      was_pressed_r <= 1'b0;
      press_start_r <= '0;
      long_done_r   <= 1'b0;
      await_r       <= 1'b0;
      first_rel_r   <= '0;
      ev_r          <= '0;
    end else if (s1_fire) begin
      was_pressed_r <= was_pressed_nxt;
      press_start_r <= press_start_nxt;
      long_done_r   <= long_done_nxt;
      await_r       <= await_nxt;
      first_rel_r   <= first_rel_nxt;
      ev_r          <= ev_nxt;
    end
  end

  // result register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (advance) begin
      out_valid_r <= s1_valid_r;
    end
  end

  always_ff @(posedge clk) begin
    if (s1_fire) begin
      out_ev_r <= res_ev;
    end
  end

`include "button_gesture_detector_top_assert.svh"

  `BGD_ASSERT_NEXT(a_consume_clears, cons_fire, ev_r == '0, "consume left flags set")
  `BGD_ASSERT_NOW(a_long_needs_press, long_done_r, was_pressed_r, "long hold while released")
  `BGD_ASSERT_NEXT(a_poll_keeps, poll_fire, (ev_r & $past(ev_r)) == $past(ev_r), "flag lost")
  `BGD_ASSERT_NEXT(a_poll_result, poll_fire, out_valid_r && (out_ev_r == ev_r), "poll result off")

endmodule

FILE: dv/testbench.sv
`timescale 1ns / 1ps
// testbench for the button gesture detector: directed and random gesture streams checked against a local predictor
module testbench;
  import bgd_pkg::*;

  localparam int unsigned CYCLE_LIMIT   = 200000;
  localparam int unsigned SETTLE_CYCLES = 8;
  localparam logic        PIN_PRESSED   = 1'b0;
  localparam logic        PIN_RELEASED  = 1'b1;

  logic                  clk;
  logic                  rst_n;
  logic                  in_tvalid;
  logic                  in_tready;
  logic [IN_DATA_W-1:0]  in_tdata;
  logic                  in_tuser;
  logic                  out_tvalid;
  logic                  out_tready = 1'b0;
  logic [OUT_DATA_W-1:0] out_tdata;
  logic                  cfg_valid;
  logic                  cfg_ready;
  logic [CFG_IDX_W-1:0]  cfg_index;
  logic [CFG_W-1:0]      cfg_data;

  // predicted register settings and gesture state
  logic [CFG_W-1:0] long_ms;
  logic [CFG_W-1:0] min_ms;
  logic [CFG_W-1:0] max_ms;
  logic [CFG_W-1:0] win_ms;
  logic             held;
  logic [31:0]      press_t;
  logic             long_fired;
  logic             wait_second;
  logic [31:0]      release_t;
  logic [2:0]       events;

  logic [2:0]  flags_due[$];
  logic [2:0]  flags_want;
  int unsigned mismatches = 0;
  int unsigned cycles = 0;
  int unsigned requests_sent = 0;
  bit          tx_jitter;
  bit          rx_jitter;
  logic [31:0] now_ms;

  button_gesture_detector_top uut (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .in_tuser   (in_tuser),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .cfg_valid  (cfg_valid),
    .cfg_ready  (cfg_ready),
    .cfg_index  (cfg_index),
    .cfg_data   (cfg_data)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles >= CYCLE_LIMIT) begin
      $display("testbench: errors");
      $finish;
    end
  end

  always @(posedge clk) out_tready <= !rx_jitter || ($urandom_range(99) >= 30);

  always @(posedge clk) begin
    if (rst_n && out_tvalid && out_tready) begin
      if (flags_due.size() == 0) begin
        mismatches++;
        if (mismatches <= 10) $display("unexpected result %03b", out_tdata[2:0]);
      end else begin
        flags_want = flags_due.pop_front();
        if (out_tdata[EV_CLICK] !== flags_want[EV_CLICK] ||
            out_tdata[EV_DOUBLE] !== flags_want[EV_DOUBLE] ||
            out_tdata[EV_LONG] !== flags_want[EV_LONG]) begin
          mismatches++;
          if (mismatches <= 10)
            $display("mismatch: click %b/%b double %b/%b long %b/%b (expected/actual)",
                     flags_want[EV_CLICK], out_tdata[EV_CLICK],
                     flags_want[EV_DOUBLE], out_tdata[EV_DOUBLE],
                     flags_want[EV_LONG], out_tdata[EV_LONG]);
        end
      end
    end
  end

  function automatic longint elapsed_ms(input logic [31:0] stamp, input logic [31:0] since);
    return longint'({32'h0, stamp}) - longint'({32'h0, since});
  endfunction

  // advances the gesture state by one request and returns the flags it reports
  function automatic logic [2:0] next_flags(input logic op, input logic pin,
                                            input logic [31:0] stamp);
    logic [2:0] seen;
    longint     win;
    longint     dur;
    logic       pressed;
    win = longint'({48'h0, win_ms});
    if (op == OP_CONSUME) begin
      seen = events;
      events = '0;
      return seen;
    end
    pressed = (pin == PIN_PRESSED);
    if (pressed && !held) begin
      press_t = stamp;
      long_fired = 1'b0;
    end else if (!pressed && held) begin
      dur = elapsed_ms(stamp, press_t);
      if (!long_fired && dur >= longint'({48'h0, min_ms}) &&
          dur <= longint'({48'h0, max_ms})) begin
        if (wait_second && win > 0 && elapsed_ms(stamp, release_t) <= win) begin
          events[EV_DOUBLE] = 1'b1;
          wait_second = 1'b0;
          release_t = '0;
        end else begin
          events[EV_CLICK] = 1'b1;
          wait_second = (win > 0);
          release_t = (win > 0) ? stamp : '0;
        end
      end
      press_t = '0;
      long_fired = 1'b0;
    end else if (pressed && !long_fired &&
                 elapsed_ms(stamp, press_t) >= longint'({48'h0, long_ms})) begin
      events[EV_LONG] = 1'b1;
      long_fired = 1'b1;
      wait_second = 1'b0;
      release_t = '0;
    end
    held = pressed;
    if (wait_second && (win == 0 || elapsed_ms(stamp, release_t) > win)) begin
      wait_second = 1'b0;
      release_t = '0;
    end
    return events;
  endfunction

  task automatic send_request(input logic op, input logic pin, input logic [31:0] stamp);
    if (tx_jitter && $urandom_range(99) < 30) begin
      in_tvalid <= 1'b0;
      repeat ($urandom_range(1, 3)) @(posedge clk);
    end
    in_tvalid <= 1'b1;
    in_tuser  <= op;
    in_tdata  <= {{(IN_DATA_W-33){1'b0}}, stamp, pin};
    do @(posedge clk); while (!in_tready);
    flags_due.push_back(next_flags(op, pin, stamp));
    requests_sent++;
  endtask

  task automatic consume_flags();
    send_request(OP_CONSUME, 1'($urandom), $urandom);
  endtask

  task automatic wait_drained();
    in_tvalid <= 1'b0;
    while (flags_due.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  // writes all four registers plus one index past the last register
  task automatic set_config(input logic [CFG_W-1:0] lp, input logic [CFG_W-1:0] mn,
                            input logic [CFG_W-1:0] mx, input logic [CFG_W-1:0] wn);
    logic [CFG_W-1:0]     vals [4];
    logic [CFG_IDX_W-1:0] regs [4];
    vals = '{lp, mn, mx, wn};
    regs = '{REG_HOLD_THR, REG_SHORT_MIN, REG_SHORT_MAX, REG_DOUBLE_WIN};
    wait_drained();
    cfg_valid <= 1'b1;
    for (int r = 0; r < 5; r++) begin
      cfg_index <= (r < 4) ? regs[r] : CFG_IDX_W'(REG_DOUBLE_WIN + 1 + $urandom_range(0, 251));
      cfg_data  <= (r < 4) ? vals[r] : CFG_W'($urandom);
      do @(posedge clk); while (!cfg_ready);
    end
    cfg_valid <= 1'b0;
    long_ms = lp;
    min_ms  = mn;
    max_ms  = mx;
    win_ms  = wn;
  endtask

  // press at now_ms, held samples spread over the hold, release at now_ms + hold
  task automatic press_gesture(input int unsigned hold, input int unsigned samples);
    send_request(OP_POLL, PIN_PRESSED, now_ms);
    for (int unsigned k = 1; k <= samples; k++)
      send_request(OP_POLL, PIN_PRESSED, now_ms + hold * k / samples);
    now_ms += hold;
    send_request(OP_POLL, PIN_RELEASED, now_ms);
  endtask

  function automatic int unsigned pick_hold();
    int h;
    case ($urandom_range(0, 7))
      0:       h = int'(min_ms) - 1;
      1:       h = int'(min_ms);
      2:       h = int'(max_ms);
      3:       h = int'(max_ms) + 1;
      4:       h = int'(long_ms) - 1;
      5:       h = int'(long_ms);
      default: h = $urandom_range(0, int'(max_ms) + 20);
    endcase
    return (h < 0) ? 0 : h;
  endfunction

  task automatic test_reset_values();
    send_request(OP_POLL, PIN_PRESSED, 32'd0);
    send_request(OP_POLL, PIN_PRESSED, 32'd999);
    send_request(OP_POLL, PIN_PRESSED, 32'd1000);
    send_request(OP_POLL, PIN_RELEASED, 32'd1200);
    consume_flags();
    send_request(OP_POLL, PIN_PRESSED, 32'd1300);
    send_request(OP_POLL, PIN_RELEASED, 32'd1400);
    consume_flags();
  endtask

  task automatic test_double_click();
    set_config(16'd1000, 16'd30, 16'd500, 16'd300);
    send_request(OP_POLL, PIN_PRESSED, 32'd2000);
    send_request(OP_POLL, PIN_RELEASED, 32'd2100);
    send_request(OP_POLL, PIN_PRESSED, 32'd2150);
    send_request(OP_POLL, PIN_RELEASED, 32'd2250);
    consume_flags();
  endtask

  task automatic test_time_edges();
    set_config(16'd0, 16'd0, 16'hFFFF, 16'hFFFF);
    // zero threshold fires on the first held sample
    send_request(OP_POLL, PIN_PRESSED, 32'hFFFF_FFF0);
    send_request(OP_POLL, PIN_PRESSED, 32'hFFFF_FFF0);
    send_request(OP_POLL, PIN_RELEASED, 32'hFFFF_FFF8);
    // backwards timestamp gives a negative duration
    send_request(OP_POLL, PIN_PRESSED, 32'd5000);
    send_request(OP_POLL, PIN_RELEASED, 32'd4000);
    // click at the top of the range, then a wrapped second click
    send_request(OP_POLL, PIN_PRESSED, 32'hFFFF_FF00);
    send_request(OP_POLL, PIN_RELEASED, 32'hFFFF_FFFF);
    send_request(OP_POLL, PIN_PRESSED, 32'd10);
    send_request(OP_POLL, PIN_RELEASED, 32'd20);
    consume_flags();
  endtask

  task automatic test_inverted_bounds();
    set_config(16'd1000, 16'd200, 16'd100, 16'd0);
    send_request(OP_POLL, PIN_PRESSED, 32'd0);
    send_request(OP_POLL, PIN_RELEASED, 32'd150);
    consume_flags();
  endtask

  task automatic run_gestures(input int unsigned count);
    int unsigned stop_at;
    stop_at = requests_sent + count;
    while (requests_sent < stop_at) begin
      case ($urandom_range(0, 9))
        0: consume_flags();
        1: begin
          case ($urandom_range(0, 3))
            0:       now_ms = $urandom;
            1:       now_ms -= $urandom_range(1, 300);
            default: now_ms += $urandom_range(0, 100);
          endcase
          send_request(1'($urandom), 1'($urandom), now_ms);
        end
        default: begin
          now_ms += ($urandom_range(0, 1) != 0) ? $urandom_range(0, int'(win_ms) / 2 + 5)
                                                : $urandom_range(0, int'(win_ms) + 100);
          press_gesture(pick_hold(), $urandom_range(0, 3));
        end
      endcase
    end
  endtask

  task automatic test_random_gestures();
    now_ms = 32'd10000;
    set_config(16'd400, 16'd20, 16'd150, 16'd250);
    run_gestures(110);
    // pause with every result delivered, no configuration change
    wait_drained();
    run_gestures(20);
    set_config(16'hFFFF, 16'd0, 16'hFFFF, 16'hFFFF);
    run_gestures(40);
    set_config(16'd300, 16'd200, 16'd100, 16'd200);
    run_gestures(80);
    repeat (3) begin
      set_config(CFG_W'($urandom_range(0, 500)), CFG_W'($urandom_range(0, 60)),
                 CFG_W'($urandom_range(0, 300)),
                 ($urandom_range(0, 2) == 0) ? '0 : CFG_W'($urandom_range(1, 400)));
      run_gestures(125);
    end
  endtask

  task automatic test_steady_stream();
    set_config(16'd250, 16'd10, 16'd120, 16'd180);
    tx_jitter = 1'b0;
    rx_jitter = 1'b0;
    run_gestures(120);
    tx_jitter = 1'b1;
    rx_jitter = 1'b1;
  endtask

  initial begin
    rst_n     <= 1'b0;
    in_tvalid <= 1'b0;
    in_tuser  <= OP_POLL;
    in_tdata  <= '0;
    cfg_valid <= 1'b0;
    cfg_index <= REG_HOLD_THR;
    cfg_data  <= '0;
    long_ms     = HOLD_THR_RST;
    min_ms      = SHORT_MIN_RST;
    max_ms      = SHORT_MAX_RST;
    win_ms      = DOUBLE_WIN_RST;
    held        = 1'b0;
    press_t     = '0;
    long_fired  = 1'b0;
    wait_second = 1'b0;
    release_t   = '0;
    events      = '0;
    tx_jitter   = 1'b1;
    rx_jitter   = 1'b1;
    now_ms      = '0;
    repeat (3) @(posedge clk);
    rst_n <= 1'b1;

    test_reset_values();
    test_double_click();
    test_time_edges();
    test_inverted_bounds();
    test_random_gestures();
    test_steady_stream();

    in_tvalid <= 1'b0;
    while (flags_due.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
    if (mismatches == 0 && flags_due.size() == 0) begin
      $display("testbench: clean");
    end else begin
      $display("testbench: errors");
    end
    $finish;
  end

endmodule
